### sv/vph_pkg.sv
// Package with the shared types and constants of the vacuum pump hysteresis controller.
`timescale 1ns / 1ps
`default_nettype none

package vph_pkg;

    localparam int P_BITS      = 16;
    localparam int T_BITS      = 16;
    localparam int LVL_BITS    = P_BITS + 1;
    localparam int PCT_BITS    = 7;
    localparam int FACTOR_BITS = 8;
    localparam int LIMIT_BITS  = 8;
    localparam int RETRY_BITS  = LIMIT_BITS + 1;
    localparam int PROD_BITS   = P_BITS + FACTOR_BITS;
    localparam int RECIP_SHIFT = PROD_BITS + 8;
    localparam int RECIP_BITS  = RECIP_SHIFT - 5;
    localparam longint unsigned RECIP_MUL = ((64'd1 << RECIP_SHIFT) + 64'd99) / 64'd100;
    localparam logic [PCT_BITS-1:0]    PCT_MAX  = 7'd100;
    localparam logic [FACTOR_BITS-1:0] PCT_FULL = 8'd100;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] CFG_TARGET       = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_UPPER_PCT    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LOWER_PCT    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TOTAL_TIME   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FIRST_SETTLE = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LATER_SETTLE = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_OFF      = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RESTART_LIM  = 3'd7;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ARMED,
        PH_FIRST_RUN,
        PH_FIRST_WAIT,
        PH_NEXT_RUN,
        PH_NEXT_WAIT
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BUSY,
        ST_STABLE,
        ST_BELOW,
        ST_TIMEOUT,
        ST_UNSTABLE
    } t_status;

    typedef struct packed {
        logic [P_BITS-1:0]     target;
        logic [PCT_BITS-1:0]   upper_pct;
        logic [PCT_BITS-1:0]   lower_pct;
        logic [T_BITS-1:0]     total_time;
        logic [T_BITS-1:0]     first_settle;
        logic [T_BITS-1:0]     later_settle;
        logic [T_BITS-1:0]     min_off;
        logic [LIMIT_BITS-1:0] restart_limit;
    } t_cfg;

    typedef struct packed {
        logic              pump_on;
        t_status           status;
        logic [T_BITS-1:0] elapsed_ticks;
    } t_result;

endpackage

`default_nettype wire

### sv/vph_if.sv
// Handshake interfaces for the input and result words of the controller.
`timescale 1ns / 1ps
`default_nettype none

interface vph_in_if;
    logic                      valid;
    logic                      ready;
    logic                      mode;
    logic [vph_pkg::P_BITS-1:0] pressure;

    modport source (output valid, output mode, output pressure, input ready);
    modport sink (input valid, input mode, input pressure, output ready);
endinterface

interface vph_out_if;
    logic                      valid;
    logic                      ready;
    logic                      pump_on;
    logic [2:0]                status;
    logic [vph_pkg::T_BITS-1:0] elapsed_ticks;

    modport source (output valid, output pump_on, output status, output elapsed_ticks,
                    input ready);
    modport sink (input valid, input pump_on, input status, input elapsed_ticks,
                  output ready);
endinterface

`default_nettype wire

### sv/vph_levels.sv
// Hysteresis level computation: registered percent scaling followed by a combinational division by 100.
`timescale 1ns / 1ps
`default_nettype none

module vph_levels (
    input  wire logic                          i_clk,
    input  wire logic [vph_pkg::P_BITS-1:0]    i_target,
    input  wire logic [vph_pkg::PCT_BITS-1:0]  i_upper_pct,
    input  wire logic [vph_pkg::PCT_BITS-1:0]  i_lower_pct,
    output logic      [vph_pkg::LVL_BITS-1:0]  o_upper,
    output logic      [vph_pkg::P_BITS-1:0]    o_lower
);

    localparam int PB = vph_pkg::PROD_BITS;
    localparam int RB = vph_pkg::RECIP_BITS;
    localparam logic [RB-1:0] RECIP = RB'(vph_pkg::RECIP_MUL);

    logic [vph_pkg::PCT_BITS-1:0]    w_up_pct;
    logic [vph_pkg::PCT_BITS-1:0]    w_dn_pct;
    logic [vph_pkg::FACTOR_BITS-1:0] w_up_factor;
    logic [vph_pkg::FACTOR_BITS-1:0] w_dn_factor;
    logic [PB-1:0]                   r_prod_up;
    logic [PB-1:0]                   r_prod_dn;
    logic [PB+RB-1:0]                w_up_scaled;
    logic [PB+RB-1:0]                w_dn_scaled;

    assign w_up_pct    = (i_upper_pct > vph_pkg::PCT_MAX) ? vph_pkg::PCT_MAX : i_upper_pct;
    assign w_dn_pct    = (i_lower_pct > vph_pkg::PCT_MAX) ? vph_pkg::PCT_MAX : i_lower_pct;
    assign w_up_factor = vph_pkg::PCT_FULL + {1'b0, w_up_pct};
    assign w_dn_factor = vph_pkg::PCT_FULL - {1'b0, w_dn_pct};

    always_ff @(posedge i_clk) begin
        r_prod_up <= PB'(i_target) * PB'(w_up_factor);
        r_prod_dn <= PB'(i_target) * PB'(w_dn_factor);
    end

    // Division by 100 as a multiplication by the rounded-up reciprocal, exact for this range.
    assign w_up_scaled = (PB+RB)'(r_prod_up) * (PB+RB)'(RECIP);
    assign w_dn_scaled = (PB+RB)'(r_prod_dn) * (PB+RB)'(RECIP);

    assign o_upper = w_up_scaled[vph_pkg::RECIP_SHIFT +: vph_pkg::LVL_BITS];
    assign o_lower = w_dn_scaled[vph_pkg::RECIP_SHIFT +: vph_pkg::P_BITS];

endmodule

`default_nettype wire

### sv/vph_ctrl.sv
// Regulation state machine: phase, time budget, retries and latched hysteresis levels.
`timescale 1ns / 1ps
`default_nettype none

module vph_ctrl (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_step,
    input  wire logic                       i_mode,
    input  wire logic [vph_pkg::P_BITS-1:0] i_pressure,
    input  wire vph_pkg::t_cfg              i_cfg,
    output vph_pkg::t_result                o_result
);

    localparam int TB = vph_pkg::T_BITS;
    localparam int RB = vph_pkg::RETRY_BITS;

    vph_pkg::t_phase              r_phase, n_phase;
    logic [TB-1:0]                r_time_left, n_time_left;
    logic [TB-1:0]                r_entry, n_entry;
    logic signed [RB-1:0]         r_retries, n_retries;
    logic [vph_pkg::LVL_BITS-1:0] r_upper, n_upper;
    logic [vph_pkg::P_BITS-1:0]   r_lower, n_lower;
    logic                         r_pump, n_pump;
    vph_pkg::t_status             r_status, n_status;
    logic                         r_has_run, n_has_run;

    logic [vph_pkg::LVL_BITS-1:0] w_lvl_upper;
    logic [vph_pkg::P_BITS-1:0]   w_lvl_lower;
    logic [TB-1:0]                w_tl_base;
    logic [TB-1:0]                w_tl_dec;
    logic [TB-1:0]                w_waited;
    logic [TB-1:0]                w_settle;
    logic signed [RB-1:0]         w_retries_dec;
    logic [vph_pkg::LVL_BITS-1:0] w_press_ext;

    vph_levels u_levels (
        .i_clk       (i_clk),
        .i_target    (i_cfg.target),
        .i_upper_pct (i_cfg.upper_pct),
        .i_lower_pct (i_cfg.lower_pct),
        .o_upper     (w_lvl_upper),
        .o_lower     (w_lvl_lower)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= vph_pkg::PH_IDLE;
            r_time_left <= '0;
            r_entry     <= '0;
            r_retries   <= '0;
            r_upper     <= '0;
            r_lower     <= '0;
            r_pump      <= 1'b0;
            r_status    <= vph_pkg::ST_IDLE;
            r_has_run   <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_time_left <= n_time_left;
            r_entry     <= n_entry;
            r_retries   <= n_retries;
            r_upper     <= n_upper;
            r_lower     <= n_lower;
            r_pump      <= n_pump;
            r_status    <= n_status;
            r_has_run   <= n_has_run;
        end
    end

    assign w_tl_base     = (r_phase == vph_pkg::PH_ARMED) ? i_cfg.total_time : r_time_left;
    assign w_tl_dec      = w_tl_base - TB'(1);
    assign w_waited      = r_entry - w_tl_dec;
    assign w_settle      = (r_phase == vph_pkg::PH_FIRST_WAIT) ? i_cfg.first_settle
                                                               : i_cfg.later_settle;
    assign w_retries_dec = r_retries - RB'(1);
    assign w_press_ext   = vph_pkg::LVL_BITS'(i_pressure);

    always_comb begin
        n_phase     = r_phase;
        n_time_left = r_time_left;
        n_entry     = r_entry;
        n_retries   = r_retries;
        n_upper     = r_upper;
        n_lower     = r_lower;
        n_pump      = r_pump;
        n_status    = r_status;
        n_has_run   = r_has_run;

        if (i_step) begin
            if (i_mode) begin
                n_phase   = vph_pkg::PH_ARMED;
                n_pump    = 1'b0;
                n_status  = vph_pkg::ST_BUSY;
                n_has_run = 1'b1;
            end else if (r_phase != vph_pkg::PH_IDLE) begin
                if (r_phase == vph_pkg::PH_ARMED) begin
                    n_upper = w_lvl_upper;
                    n_lower = w_lvl_lower;
                end
                n_time_left = w_tl_dec;
                if (w_tl_dec == '0) begin
                    n_phase  = vph_pkg::PH_IDLE;
                    n_pump   = 1'b0;
                    n_status = vph_pkg::ST_TIMEOUT;
                end else begin
                    case (r_phase)
                        vph_pkg::PH_ARMED: begin
                            if (i_pressure < i_cfg.target) begin
                                n_phase  = vph_pkg::PH_IDLE;
                                n_pump   = 1'b0;
                                n_status = vph_pkg::ST_BELOW;
                            end else begin
                                n_phase = vph_pkg::PH_FIRST_RUN;
                                n_entry = w_tl_dec;
                                n_pump  = 1'b1;
                            end
                        end
                        vph_pkg::PH_FIRST_RUN, vph_pkg::PH_NEXT_RUN: begin
                            if (i_pressure < r_lower) begin
                                if (r_phase == vph_pkg::PH_FIRST_RUN) begin
                                    n_retries = $signed({1'b0, i_cfg.restart_limit}) - RB'(1);
                                    n_phase   = vph_pkg::PH_FIRST_WAIT;
                                end else begin
                                    n_phase = vph_pkg::PH_NEXT_WAIT;
                                end
                                n_pump  = 1'b0;
                                n_entry = w_tl_dec;
                            end
                        end
                        vph_pkg::PH_FIRST_WAIT, vph_pkg::PH_NEXT_WAIT: begin
                            if (w_press_ext < r_upper && w_waited > w_settle) begin
                                n_phase  = vph_pkg::PH_IDLE;
                                n_pump   = 1'b0;
                                n_status = vph_pkg::ST_STABLE;
                            end else if (w_press_ext > r_upper && w_waited > i_cfg.min_off) begin
                                if (r_phase == vph_pkg::PH_NEXT_WAIT) begin
                                    n_retries = w_retries_dec;
                                end
                                if (r_phase == vph_pkg::PH_NEXT_WAIT &&
                                    (w_retries_dec[RB-1] || w_retries_dec == '0)) begin
                                    n_phase  = vph_pkg::PH_IDLE;
                                    n_pump   = 1'b0;
                                    n_status = vph_pkg::ST_UNSTABLE;
                                end else begin
                                    n_phase = vph_pkg::PH_NEXT_RUN;
                                    n_entry = w_tl_dec;
                                    n_pump  = 1'b1;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
        end

        o_result.pump_on = n_pump;
        o_result.status  = n_status;
        if (!n_has_run || n_phase == vph_pkg::PH_ARMED) begin
            o_result.elapsed_ticks = '0;
        end else begin
            o_result.elapsed_ticks = i_cfg.total_time - n_time_left;
        end
    end

endmodule

`default_nettype wire

### sv/vacuum_pump_hysteresis_controller_top.sv
// Top level of the vacuum pump hysteresis controller: configuration, handshake and registers.
`timescale 1ns / 1ps
`default_nettype none

// The controller takes one word per clock cycle while the output is not stalled and returns
// exactly one result word for each. A word accepted at a clock edge sits in the input register,
// is evaluated by a single pass of compare and update logic, and its result is loaded into the
// output register when the word steps, while the following word is already being taken. A
// stalled output holds the pipeline, and the input stays ready as long as the input register
// can move on. The hysteresis levels come from a registered multiply on the configuration
// registers and a combinational division, and are latched when the first tick after a start
// word is evaluated. There is no clearing pass after reset.
module vacuum_pump_hysteresis_controller_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    vph_in_if.sink                                 i_in,
    vph_out_if.source                              o_out,
    input  wire logic                              i_cfg_we,
    input  wire logic [vph_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire logic [vph_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);

    vph_pkg::t_cfg              r_cfg;
    logic                       r_in_vld;
    logic                       r_in_mode;
    logic [vph_pkg::P_BITS-1:0] r_in_pressure;
    logic                       r_out_vld;
    vph_pkg::t_result           r_out_res;
    vph_pkg::t_result           w_result;
    logic                       w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target        <= '0;
            r_cfg.upper_pct     <= 7'd5;
            r_cfg.lower_pct     <= 7'd5;
            r_cfg.total_time    <= vph_pkg::T_BITS'(6000);
            r_cfg.first_settle  <= vph_pkg::T_BITS'(100);
            r_cfg.later_settle  <= vph_pkg::T_BITS'(100);
            r_cfg.min_off       <= vph_pkg::T_BITS'(50);
            r_cfg.restart_limit <= 8'd3;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                vph_pkg::CFG_TARGET: begin
                    r_cfg.target <= vph_pkg::P_BITS'(i_cfg_data);
                end
                vph_pkg::CFG_UPPER_PCT: begin
                    r_cfg.upper_pct <= i_cfg_data[vph_pkg::PCT_BITS-1:0];
                end
                vph_pkg::CFG_LOWER_PCT: begin
                    r_cfg.lower_pct <= i_cfg_data[vph_pkg::PCT_BITS-1:0];
                end
                vph_pkg::CFG_TOTAL_TIME: begin
                    r_cfg.total_time <= vph_pkg::T_BITS'(i_cfg_data);
                end
                vph_pkg::CFG_FIRST_SETTLE: begin
                    r_cfg.first_settle <= vph_pkg::T_BITS'(i_cfg_data);
                end
                vph_pkg::CFG_LATER_SETTLE: begin
                    r_cfg.later_settle <= vph_pkg::T_BITS'(i_cfg_data);
                end
                vph_pkg::CFG_MIN_OFF: begin
                    r_cfg.min_off <= vph_pkg::T_BITS'(i_cfg_data);
                end
                vph_pkg::CFG_RESTART_LIM: begin
                    r_cfg.restart_limit <= i_cfg_data[vph_pkg::LIMIT_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign w_step     = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_in_vld || w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_mode     <= i_in.mode;
            r_in_pressure <= i_in.pressure;
        end
    end

    vph_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (w_step),
        .i_mode     (r_in_mode),
        .i_pressure (r_in_pressure),
        .i_cfg      (r_cfg),
        .o_result   (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_step) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_res <= w_result;
        end
    end

    assign o_out.valid         = r_out_vld;
    assign o_out.pump_on       = r_out_res.pump_on;
    assign o_out.status        = r_out_res.status;
    assign o_out.elapsed_ticks = r_out_res.elapsed_ticks;

    // A finished run always leaves the pump switched off.
    a_pump_off_when_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_res.status != vph_pkg::ST_BUSY) |-> !r_out_res.pump_on)
        else $error("pump reported running after the run ended");

    // Every evaluated word lands in the output register.
    a_step_loads_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |=> r_out_vld)
        else $error("evaluated word did not reach the output register");

    // A start word arms the controller with the pump off and no elapsed time.
    a_start_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && r_in_mode) |=> (r_out_res.status == vph_pkg::ST_BUSY &&
                                   !r_out_res.pump_on && r_out_res.elapsed_ticks == '0))
        else $error("start word produced a wrong result");

endmodule

`default_nettype wire
